// ===== src/fcf_pkg.sv =====
package fcf_pkg;

  localparam int FCF_MAX_TAPS_DEF = 256;

  localparam int FCF_SAMPLE_W   = 32;
  localparam int FCF_COEF_W     = 16;
  localparam int FCF_IDX_W      = 8;
  localparam int FCF_TAPCNT_W   = 9;
  localparam int FCF_SHIFT_W    = 6;
  localparam int FCF_TOTAL_W    = 7;
  localparam int FCF_MAX_LSHIFT = 15;

  localparam int FCF_CFG_IDX_W  = 1;
  localparam int FCF_CFG_DATA_W = 9;

  localparam logic [FCF_CFG_IDX_W-1:0] CFG_TAP_COUNT    = 1'd0;
  localparam logic [FCF_CFG_IDX_W-1:0] CFG_OUTPUT_SHIFT = 1'd1;

  localparam logic FCF_MODE_FILTER = 1'b0;
  localparam logic FCF_MODE_COEF   = 1'b1;

  // Q1.15 coefficients: products are renormalized by 15 bits
  localparam logic signed [FCF_TOTAL_W-1:0] FCF_BASE_SHIFT = 7'sd15;
  localparam logic signed [FCF_SHIFT_W-1:0] FCF_SHIFT_LIM  = 6'sd30;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_SHIFT,
    S_OUT
  } fcf_state_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic issue;   // a tap read was issued this cycle
    logic tap_ok;  // history entry of this tap has been written since reset
    logic y_acc;   // load the scaled accumulator into the result register
    logic y_pass;  // load the incoming sample into the result register
  } dp_ctl_t;

endpackage

// ===== src/fcf_if.sv =====
interface fcf_in_if
  import fcf_pkg::*;
;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic signed [FCF_SAMPLE_W-1:0] sample_in;
  logic        [FCF_IDX_W-1:0]    coef_index;
  logic signed [FCF_COEF_W-1:0]   coef_value;

  modport source (output valid, output mode, output sample_in, output coef_index,
                  output coef_value, input ready);
  modport sink (input valid, input mode, input sample_in, input coef_index,
                input coef_value, output ready);
endinterface

interface fcf_out_if
  import fcf_pkg::*;
;
  logic                           valid;
  logic                           ready;
  logic signed [FCF_SAMPLE_W-1:0] sample_out;
  logic                           saturated;

  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// ===== src/fcf_ram.sv =====
module fcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fcf_datapath.sv =====
module fcf_datapath
  import fcf_pkg::*;
#(
  parameter int ACC_W = 57
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dp_ctl_t                         ctl,
  input  logic        [FCF_COEF_W-1:0]    coef_rd,
  input  logic        [FCF_SAMPLE_W-1:0]  hist_rd,
  input  logic signed [FCF_TOTAL_W-1:0]   total_shift,
  input  logic signed [FCF_SAMPLE_W-1:0]  pass_sample,
  output logic                            busy,
  output logic signed [FCF_SAMPLE_W-1:0]  res_sample,
  output logic                            res_sat
);

  localparam int PROD_W = FCF_COEF_W + FCF_SAMPLE_W;
  localparam int Y_W    = ACC_W + FCF_MAX_LSHIFT;

  logic                      issue_r;
  logic                      ok_r;
  logic                      prod_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [Y_W-1:0]     acc_ext;
  logic signed [Y_W-1:0]     y_r;
  logic signed [Y_W-1:0]     y_nxt;
  logic [FCF_TOTAL_W-1:0]    neg_total;
  logic                      all_ones;
  logic                      all_zeros;

  // RAM data shows up in the cycle after the issue; zero taps that reach unwritten history
  always_comb begin
    if (ok_r) begin
      prod_nxt = $signed(coef_rd) * $signed(hist_rd);
    end else begin
      prod_nxt = '0;
    end
  end

  assign acc_ext   = Y_W'(acc_r);
  assign neg_total = FCF_TOTAL_W'(-total_shift);

  always_comb begin
    if (!total_shift[FCF_TOTAL_W-1]) begin
      y_nxt = acc_ext >>> total_shift[FCF_TOTAL_W-2:0];
    end else begin
      y_nxt = acc_ext <<< neg_total[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r  <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      issue_r  <= ctl.issue;
      prod_v_r <= issue_r;
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ctl.tap_ok;
    prod_r <= prod_nxt;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (ctl.y_acc) begin
      y_r <= y_nxt;
    end else if (ctl.y_pass) begin
      y_r <= Y_W'(pass_sample);
    end
  end

  assign busy = issue_r | prod_v_r;

  // in range when every bit above bit 30 equals the sign
  assign all_ones  = &y_r[Y_W-1:FCF_SAMPLE_W-1];
  assign all_zeros = ~|y_r[Y_W-1:FCF_SAMPLE_W-1];
  assign res_sat   = ~(all_ones | all_zeros);

  always_comb begin
    if (!res_sat) begin
      res_sample = y_r[FCF_SAMPLE_W-1:0];
    end else if (y_r[Y_W-1]) begin
      res_sample = {1'b1, {(FCF_SAMPLE_W-1){1'b0}}};
    end else begin
      res_sample = {1'b0, {(FCF_SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ===== src/fir_filter_circular_history_top.sv =====
// FIR filter over a circular sample history.
// Input channel in_ch: mode 1 stores coef_value at tap coef_index (no result),
// mode 0 filters sample_in and gives one result on out_ch (sample_out and the
// saturated flag). Config port: cfg_we with cfg_index 0 sets tap_count,
// index 1 sets output_shift; write only while the block is idle.
// A coefficient transfer leaves in_ch.ready high.
// Pass-through (tap_count 0): the sample goes through the result register
// to out_ch; the next item waits until the result is loaded for output.
// Filtering with N taps: the history and coefficient RAMs are read once per
// tap through one multiplier and accumulator; the next item is taken only
// after the result has been loaded into the output register.
// A result waiting in the output register does not hold off the next item;
// a stalled receiver only blocks the block when a second result is done.
// Reset clears tap_count, output_shift, the write position and the history
// fill count; history entries never written since reset read as zero.
// Coefficients are undefined until written.
module fir_filter_circular_history_top
  import fcf_pkg::*;
#(
  parameter int MAX_TAPS = FCF_MAX_TAPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  fcf_in_if.sink                    in_ch,
  fcf_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [FCF_CFG_IDX_W-1:0]  cfg_index,
  input  logic [FCF_CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int CMP_W  = (CNT_W > FCF_TAPCNT_W) ? CNT_W : FCF_TAPCNT_W;
  localparam int ACC_W  = FCF_COEF_W + FCF_SAMPLE_W + ADDR_W + 1;
  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(MAX_TAPS - 1);

  fcf_state_t state_r, state_nxt;

  logic        [FCF_TAPCNT_W-1:0] tap_count_r;
  logic signed [FCF_SHIFT_W-1:0]  out_shift_r;
  logic        [ADDR_W-1:0]       pos_r;
  logic        [CNT_W-1:0]        fill_r;
  logic        [ADDR_W-1:0]       k_r;
  logic        [ADDR_W-1:0]       rd_ptr_r;
  logic        [CNT_W-1:0]        taps_r;
  logic        [CNT_W-1:0]        taps_nxt;
  logic signed [FCF_TOTAL_W-1:0]  total_r;
  logic signed [FCF_TOTAL_W-1:0]  total_nxt;
  logic signed [FCF_SHIFT_W-1:0]  shift_eff;

  logic                           out_valid_r;
  logic signed [FCF_SAMPLE_W-1:0] out_sample_r;
  logic                           out_sat_r;

  logic                           in_ready;
  logic                           is_coef;
  logic                           coef_ok;
  logic                           coef_we;
  logic                           hist_we;
  logic                           start;
  logic                           out_load;
  logic                           last_tap;
  dp_ctl_t                        dp_ctl;
  logic                           dp_busy;
  logic signed [FCF_SAMPLE_W-1:0] dp_sample;
  logic                           dp_sat;
  logic        [FCF_COEF_W-1:0]   coef_rd;
  logic        [FCF_SAMPLE_W-1:0] hist_rd;

  assign is_coef  = (in_ch.mode == FCF_MODE_COEF);
  assign coef_ok  = int'(in_ch.coef_index) < MAX_TAPS;
  assign last_tap = (k_r == ADDR_W'(taps_r - CNT_W'(1)));

  always_comb begin
    if (CMP_W'(tap_count_r) > CMP_W'(MAX_TAPS)) begin
      taps_nxt = CNT_W'(MAX_TAPS);
    end else begin
      taps_nxt = CNT_W'(tap_count_r);
    end
  end

  // out-of-range shift settings fall back to no extra shift
  always_comb begin
    if (out_shift_r < -FCF_SHIFT_LIM || out_shift_r > FCF_SHIFT_LIM) begin
      shift_eff = '0;
    end else begin
      shift_eff = out_shift_r;
    end
  end
  assign total_nxt = FCF_BASE_SHIFT + FCF_TOTAL_W'(shift_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    coef_we   = 1'b0;
    hist_we   = 1'b0;
    start     = 1'b0;
    out_load  = 1'b0;
    dp_ctl    = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (is_coef) begin
            coef_we = coef_ok;
          end else if (tap_count_r == '0) begin
            dp_ctl.y_pass = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            hist_we      = 1'b1;
            start        = 1'b1;
            dp_ctl.clear = 1'b1;
            state_nxt    = S_RUN;
          end
        end
      end
      S_RUN: begin
        dp_ctl.issue  = 1'b1;
        dp_ctl.tap_ok = (CNT_W'(k_r) < fill_r);
        if (last_tap) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!dp_busy) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        dp_ctl.y_acc = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= '0;
      out_shift_r <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAP_COUNT:    tap_count_r <= cfg_wdata[FCF_TAPCNT_W-1:0];
          CFG_OUTPUT_SHIFT: out_shift_r <= $signed(cfg_wdata[FCF_SHIFT_W-1:0]);
          default: ;
        endcase
      end
      if (start) begin
        pos_r <= (pos_r == LAST_POS) ? '0 : pos_r + ADDR_W'(1);
        if (fill_r != CNT_W'(MAX_TAPS)) begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // tap k reads coefficient k and the sample k steps behind the newest one
  always_ff @(posedge clk) begin
    if (start) begin
      k_r      <= '0;
      rd_ptr_r <= pos_r;
      taps_r   <= taps_nxt;
      total_r  <= total_nxt;
    end else if (dp_ctl.issue) begin
      k_r      <= k_r + ADDR_W'(1);
      rd_ptr_r <= (rd_ptr_r == '0) ? LAST_POS : rd_ptr_r - ADDR_W'(1);
    end
    if (out_load) begin
      out_sample_r <= dp_sample;
      out_sat_r    <= dp_sat;
    end
  end

  fcf_ram #(
    .WIDTH (FCF_SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos_r),
    .wdata (in_ch.sample_in),
    .raddr (rd_ptr_r),
    .rdata (hist_rd)
  );

  fcf_ram #(
    .WIDTH (FCF_COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (ADDR_W'(in_ch.coef_index)),
    .wdata (in_ch.coef_value),
    .raddr (k_r),
    .rdata (coef_rd)
  );

  fcf_datapath #(
    .ACC_W (ACC_W)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (dp_ctl),
    .coef_rd     (coef_rd),
    .hist_rd     (hist_rd),
    .total_shift (total_r),
    .pass_sample (in_ch.sample_in),
    .busy        (dp_busy),
    .res_sample  (dp_sample),
    .res_sat     (dp_sat)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.saturated  = out_sat_r;

endmodule

// ===== src/fcf_checker.sv =====
module fcf_checker
  import fcf_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_mode,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [FCF_SAMPLE_W-1:0] out_sample,
  input logic                    out_sat
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_sat))
    else $error("result changed while stalled");

  // a coefficient write never takes the block out of idle
  a_coef_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == FCF_MODE_COEF |=> in_ready)
    else $error("coefficient transfer blocked the input");

  // a sample transfer always starts work that holds off the next item
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == FCF_MODE_FILTER |=> !in_ready)
    else $error("input ready right after a sample transfer");

  // a clipped result sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat |-> out_sample == 32'h7FFF_FFFF || out_sample == 32'h8000_0000)
    else $error("saturated result off the rails");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fir_filter_circular_history_top fcf_checker u_fcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .out_sat    (out_ch.saturated)
);

// ===== tb/sv/tb_fir_filter_circular_history_top.sv =====
`timescale 1ns / 100ps

module tb_fir_filter_circular_history_top;
  import fcf_pkg::*;

  localparam int SETTLE_CYCLES = 300;  // longest item uses all 256 taps
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic                           mode;
    logic signed [FCF_SAMPLE_W-1:0] sample;
    logic        [FCF_IDX_W-1:0]    cidx;
    logic signed [FCF_COEF_W-1:0]   cval;
  } fir_item_t;

  typedef struct {
    logic signed [FCF_SAMPLE_W-1:0] sample_out;
    logic                           saturated;
  } fir_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FCF_CFG_IDX_W-1:0]  cfg_index;
  logic [FCF_CFG_DATA_W-1:0] cfg_wdata;

  fcf_in_if  in_ch ();
  fcf_out_if out_ch ();

  fir_filter_circular_history_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // filter model state
  logic signed [FCF_COEF_W-1:0]   coef_mem [FCF_MAX_TAPS_DEF];
  logic signed [FCF_SAMPLE_W-1:0] hist_mem [FCF_MAX_TAPS_DEF];
  logic        [FCF_IDX_W-1:0]    wr_pos;
  logic        [FCF_TAPCNT_W-1:0] tap_count_q;
  logic signed [FCF_SHIFT_W-1:0]  out_shift_q;

  fir_item_t   fir_item_q [$];
  fir_result_t fir_out_due_q [$];
  fir_item_t   drv_item;

  idle_mode_t idle_mode;
  logic       hold_go;
  logic       hold_used;
  int         hold_left;

  int items_queued;
  int items_taken;
  int samples_taken;
  int coefs_taken;
  int results_seen;
  int clipped_seen;
  int cfg_writes;
  int err_cnt;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Model of one accepted item; a filtered sample queues its result.
  function automatic void fir_predict(input fir_item_t it);
    fir_result_t r;
    int taps;
    int sh;
    int total;
    int l;
    logic [FCF_IDX_W-1:0] pos;
    logic [FCF_IDX_W-1:0] h;
    logic signed [63:0] acc;
    logic signed [63:0] y;
    logic signed [63:0] c64;
    logic signed [63:0] s64;
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    if (it.mode == FCF_MODE_COEF) begin
      coef_mem[it.cidx] = it.cval;
      coefs_taken++;
      return;
    end
    samples_taken++;
    if (tap_count_q == '0) begin
      r.sample_out = it.sample;
      r.saturated  = 1'b0;
      fir_out_due_q.push_back(r);
      return;
    end
    taps = (tap_count_q > FCF_MAX_TAPS_DEF) ? FCF_MAX_TAPS_DEF : int'(tap_count_q);
    pos = wr_pos;
    hist_mem[pos] = it.sample;
    wr_pos = pos + 1'b1;
    acc = '0;
    for (int k = 0; k < taps; k++) begin
      h = pos - 8'(k);
      c64 = coef_mem[k];
      s64 = hist_mem[h];
      acc = acc + c64 * s64;
    end
    sh = out_shift_q;
    if (sh < -30 || sh > 30) sh = 0;
    total = 15 + sh;
    if (total >= 0) begin
      y = acc >>> total;
    end else begin
      // left shift: clamp before shifting so nothing wraps
      l = -total;
      hi_lim = 64'sd2147483647 >>> l;
      lo_lim = -(64'sd1 <<< (31 - l));
      if (acc > hi_lim) y = 64'sd2147483648;
      else if (acc < lo_lim) y = -64'sd2147483649;
      else y = acc <<< l;
    end
    r.saturated = 1'b0;
    if (y > 64'sd2147483647) begin
      y = 64'sd2147483647;
      r.saturated = 1'b1;
    end else if (y < -64'sd2147483648) begin
      y = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.sample_out = y[31:0];
    fir_out_due_q.push_back(r);
  endfunction

  function automatic logic sender_gap();
    case (idle_mode)
      IDLE_SRC:  return $urandom_range(0, 99) < 70;
      IDLE_BOTH: return $urandom_range(0, 99) < 28;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      IDLE_SNK:  return $urandom_range(0, 99) < 70;
      IDLE_BOTH: return $urandom_range(0, 99) < 28;
      default:   return 1'b0;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fir_predict(drv_item);
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (fir_item_q.size() != 0 && !sender_gap()) begin
          drv_item = fir_item_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.mode       <= drv_item.mode;
          in_ch.sample_in  <= drv_item.sample;
          in_ch.coef_index <= drv_item.cidx;
          in_ch.coef_value <= drv_item.cval;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once by the stimulus
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_left == 0) && !receiver_stall();
  end

  always @(posedge clk) begin : result_check
    fir_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fir_out_due_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none due: expected nothing, actual sample_out=%0d saturated=%0b",
                 $time, out_ch.sample_out, out_ch.saturated);
      end else begin
        want = fir_out_due_q.pop_front();
        results_seen++;
        if (out_ch.saturated === 1'b1) clipped_seen++;
        if (out_ch.sample_out !== want.sample_out) begin
          err_cnt++;
          $display("%0t: sample_out mismatch: expected %0d actual %0d",
                   $time, want.sample_out, out_ch.sample_out);
        end
        if (out_ch.saturated !== want.saturated) begin
          err_cnt++;
          $display("%0t: saturated mismatch: expected %0b actual %0b",
                   $time, want.saturated, out_ch.saturated);
        end
      end
    end
  end

  function automatic void queue_sample(input logic signed [FCF_SAMPLE_W-1:0] x);
    fir_item_t it;
    it.mode   = FCF_MODE_FILTER;
    it.sample = x;
    it.cidx   = 8'($urandom());
    it.cval   = 16'($urandom());
    fir_item_q.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_coef(input logic [FCF_IDX_W-1:0] idx,
                                     input logic signed [FCF_COEF_W-1:0] val);
    fir_item_t it;
    it.mode   = FCF_MODE_COEF;
    it.sample = $urandom();
    it.cidx   = idx;
    it.cval   = val;
    fir_item_q.push_back(it);
    items_queued++;
  endfunction

  function automatic logic signed [FCF_SAMPLE_W-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: begin
        v = $urandom_range(0, 4000);
        return v - 2000;
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [FCF_COEF_W-1:0] rand_coef();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: begin
        v = $urandom_range(0, 600);
        return 16'(v - 300);
      end
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [FCF_TAPCNT_W-1:0] rand_taps();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 15) return 9'($urandom_range(1, 16));
    if (r < 18) return 9'($urandom_range(17, 64));
    if (r == 18) return 9'($urandom_range(65, 256));
    return 9'($urandom_range(257, 511));
  endfunction

  function automatic logic signed [FCF_SHIFT_W-1:0] rand_shift();
    int v;
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    v = $urandom_range(0, 60);
    v = v - 30;
    return v[5:0];
  endfunction

  // everything sent has been taken and answered, and the last
  // coefficient write or tap loop has had time to finish
  task automatic wait_idle();
    while (items_taken != items_queued || fir_out_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [FCF_TAPCNT_W-1:0] taps,
                              input logic signed [FCF_SHIFT_W-1:0] shift);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TAP_COUNT;
    cfg_wdata <= taps;
    @(posedge clk);
    cfg_index <= CFG_OUTPUT_SHIFT;
    cfg_wdata <= {3'b000, shift};
    @(posedge clk);
    cfg_we <= 1'b0;
    tap_count_q = taps;
    out_shift_q = shift;
    cfg_writes += 2;
  endtask

  initial begin
    int order [FCF_MAX_TAPS_DEF];
    int j;
    int tmp;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = FCF_MODE_FILTER;
    in_ch.sample_in  = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    out_ch.ready     = 1'b0;
    hold_go          = 1'b0;
    idle_mode        = IDLE_NONE;
    wr_pos           = '0;
    tap_count_q      = '0;
    out_shift_q      = '0;
    items_queued = 0; items_taken = 0; samples_taken = 0; coefs_taken = 0;
    results_seen = 0; clipped_seen = 0; cfg_writes = 0; err_cnt = 0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // pass-through after reset, then the first four taps and the top index
    queue_sample(32'sh00000000);
    queue_sample(32'sh7fffffff);
    queue_sample(32'sh80000000);
    queue_sample(-32'sd1);
    queue_sample(32'sd1);
    queue_sample(32'sh55555555);
    queue_sample(32'shaaaaaaaa);
    queue_coef(8'd0, 16'sh8000);
    queue_coef(8'd1, 16'sh8000);
    queue_coef(8'd2, 16'sh7fff);
    queue_coef(8'd3, 16'sd1);
    queue_coef(8'd255, 16'sh1234);
    wait_idle();

    // four taps: history fill from zero, positive clipping
    write_config(9'd4, 6'sd0);
    queue_sample(32'sh80000000);
    queue_sample(32'sh80000000);
    queue_sample(32'sh80000000);
    queue_sample(32'sh80000000);
    queue_sample(32'sh7fffffff);
    queue_sample(32'sd0);
    queue_sample(-32'sd1);
    wait_idle();

    // strongest left shift: negative clipping and small values
    write_config(9'd4, -6'sd30);
    queue_sample(32'sh7fffffff);
    queue_sample(32'sd1);
    queue_sample(32'sh80000000);
    queue_sample(32'sd1000);
    wait_idle();

    // fill the whole coefficient store in shuffled order
    write_config(9'd4, 6'sd0);
    for (int i = 0; i < FCF_MAX_TAPS_DEF; i++) order[i] = i;
    for (int i = FCF_MAX_TAPS_DEF - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < FCF_MAX_TAPS_DEF; i++) begin
      queue_coef(8'(order[i]), rand_coef());
      if (i % 8 == 7) queue_sample(rand_sample());
    end
    wait_idle();

    // receiver holds off while samples keep coming, strongest right shift
    write_config(9'd8, 6'sd30);
    hold_go <= 1'b1;
    for (int i = 0; i < 40; i++) queue_sample(rand_sample());
    wait_idle();

    // every tap in use
    write_config(9'd256, rand_shift());
    idle_mode = IDLE_BOTH;
    queue_coef(8'd200, rand_coef());
    for (int i = 0; i < 12; i++) queue_sample(rand_sample());
    wait_idle();

    // tap count beyond the store and shifts outside the legal range
    write_config(9'd300, 6'sd31);
    idle_mode = IDLE_SNK;
    for (int i = 0; i < 8; i++) queue_sample(rand_sample());
    wait_idle();
    write_config(9'd511, -6'sd32);
    idle_mode = IDLE_SRC;
    for (int i = 0; i < 6; i++) queue_sample(rand_sample());
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      write_config(rand_taps(), rand_shift());
      idle_mode = idle_mode_t'(p % 4);
      for (int i = 0; i < 45; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 9) < 7) queue_coef(8'($urandom_range(0, 15)), rand_coef());
          else queue_coef(8'($urandom()), rand_coef());
        end else begin
          queue_sample(rand_sample());
        end
      end
      wait_idle();
    end

    $display("Filtered %0d samples and stored %0d coefficients across %0d register writes.",
             samples_taken, coefs_taken, cfg_writes);
    $display("Checked %0d results, %0d of them clipped.", results_seen, clipped_seen);
    if (err_cnt == 0 && fir_out_due_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
